// ===== rtl/soc_pkg.sv =====
// ----------------------------------------------------------------------------
// soc_pkg
// shared types, codes and helpers of the offset and scale calibrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package soc_pkg;

  localparam logic [1:0] REG_TARGET_NORM   = 2'd0;
  localparam logic [1:0] REG_LEARN_RATE    = 2'd1;
  localparam logic [1:0] REG_ITER_COUNT    = 2'd2;

  localparam logic [14:0] TARGET_NORM_RST  = 15'd4096;
  localparam logic [23:0] LEARN_RATE_RST   = 24'd16777;
  localparam logic [15:0] ITER_COUNT_RST   = 16'd7500;

  localparam logic signed [31:0] Q16_ONE   = 32'sd65536;
  localparam logic [6:0] SQRT_STEPS        = 7'd32;
  localparam logic [6:0] DIV_STEPS         = 7'd64;
  localparam logic [2:0] AX_LAST          = 3'd2;
  localparam logic [2:0] EST_LAST         = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WRITE,
    OP_INIT,
    OP_CLR,
    OP_READ,
    OP_DIFF,
    OP_MUL_CS,
    OP_C,
    OP_MUL_SQ,
    OP_ACC_SQ,
    OP_SQRT_START,
    OP_SQRT_STEP,
    OP_ERR,
    OP_DIV_U_START,
    OP_DIV_STEP,
    OP_U,
    OP_MUL_T,
    OP_T,
    OP_MUL_TS,
    OP_ACC_O,
    OP_MUL_TD,
    OP_ACC_S,
    OP_DIV_G_START,
    OP_M,
    OP_MUL_PH,
    OP_P_HI,
    OP_MUL_PL,
    OP_UPD
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_PASS,
    ST_READ,
    ST_DIFF,
    ST_MCS,
    ST_C,
    ST_MSQ,
    ST_ASQ,
    ST_SQS,
    ST_SQ,
    ST_ERR,
    ST_DVS,
    ST_DV,
    ST_U,
    ST_MT,
    ST_T,
    ST_MTS,
    ST_AO,
    ST_MTD,
    ST_AS,
    ST_NEXT,
    ST_GDS,
    ST_GD,
    ST_M,
    ST_MPH,
    ST_PH,
    ST_MPL,
    ST_UPD,
    ST_PEND,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] ax;
  } cmd_t;

  typedef struct packed {
    logic iter_last;
    logic norm_zero;
  } sts_t;

  function automatic logic signed [31:0] sat32_f(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48_f(input logic signed [65:0] v);
    logic signed [47:0] r;
    if (v > 66'sd140737488355327) begin
      r = 48'sh7FFFFFFFFFFF;
    end else if (v < -66'sd140737488355328) begin
      r = 48'sh800000000000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag_f(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = v[32] ? -v : v;
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sensor_offset_scale_calibrator.sv =====
// ----------------------------------------------------------------------------
// sensor_offset_scale_calibrator
// per-axis offset and scale fit by batch gradient descent over stored samples
// ----------------------------------------------------------------------------
// loading: one sample per cycle while the block is idle, written straight into the sample memory
// solve: iteration_count gradient passes over the N stored samples, built on
//   the 64-step divider, 32-step square root and the one shared multiplier
// result: loaded into the output register once the solve ends and the previous result has been taken
// reset: asynchronous, clears control state and sets registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module sensor_offset_scale_calibrator #(
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [47:0]   s_axis_tdata_i,   // sample_x, sample_y, sample_z
  input  wire logic          s_axis_tlast_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [191:0]       m_axis_tdata_o,   // offset_x/y/z, scale_x/y/z
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [23:0]   cfg_wdata_i
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [14:0]   tn_q;
  logic [23:0]   lr_q;
  logic [15:0]   it_q;
  logic          out_valid_q;
  logic [191:0]  out_data_q;
  logic          load_out;
  logic [191:0]  result;
  logic [AW-1:0] addr;
  logic [CW-1:0] count;
  soc_pkg::cmd_t cmd;
  soc_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tn_q <= soc_pkg::TARGET_NORM_RST;
      lr_q <= soc_pkg::LEARN_RATE_RST;
      it_q <= soc_pkg::ITER_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        soc_pkg::REG_TARGET_NORM: tn_q <= cfg_wdata_i[14:0];
        soc_pkg::REG_LEARN_RATE:  lr_q <= cfg_wdata_i;
        soc_pkg::REG_ITER_COUNT:  it_q <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  soc_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_last_i    (s_axis_tlast_i),
    .in_ready_o   (s_axis_tready_o),
    .iter_count_i (it_q),
    .out_busy_i   (out_valid_q),
    .load_out_o   (load_out),
    .cmd_o        (cmd),
    .sts_i        (sts),
    .addr_o       (addr),
    .count_o      (count)
  );

  soc_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .addr_i   (addr),
    .count_i  (count),
    .sample_i (s_axis_tdata_i),
    .tn_i     (tn_q),
    .lr_i     (lr_q),
    .result_o (result)
  );

endmodule

`default_nettype wire

// ===== rtl/soc_ctrl.sv =====
// ----------------------------------------------------------------------------
// soc_ctrl
// sequencer for sample loading, gradient passes and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soc_ctrl #(
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire logic                               in_last_i,
  output logic                                    in_ready_o,
  input  wire logic [15:0]                        iter_count_i,
  input  wire logic                               out_busy_i,
  output logic                                    load_out_o,
  output soc_pkg::cmd_t                           cmd_o,
  input  wire soc_pkg::sts_t                      sts_i,
  output logic [$clog2(MAX_SAMPLES)-1:0]          addr_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]        count_o
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  soc_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [15:0]     pass_q, pass_d;
  logic [2:0]      ax_q, ax_d;
  logic            take;

  assign take    = in_valid_i && (state_q == soc_pkg::ST_IDLE);
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= soc_pkg::ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      pass_q  <= '0;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
      ax_q    <= ax_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pass_d     = pass_q;
    ax_d       = ax_q;
    in_ready_o = 1'b0;
    load_out_o = 1'b0;
    cmd_o.op   = soc_pkg::OP_NONE;
    cmd_o.ax   = ax_q;
    addr_o     = idx_q;
    case (state_q)
      soc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        addr_o     = count_q[AW-1:0];
        if (take) begin
          if (count_q < CW'(MAX_SAMPLES)) begin
            cmd_o.op = soc_pkg::OP_WRITE;
            count_d  = count_q + CW'(1);
          end
          if (in_last_i) begin
            state_d = soc_pkg::ST_INIT;
          end
        end
      end
      soc_pkg::ST_INIT: begin
        cmd_o.op = soc_pkg::OP_INIT;
        pass_d   = '0;
        state_d  = (iter_count_i == 16'd0) ? soc_pkg::ST_DONE : soc_pkg::ST_PASS;
      end
      soc_pkg::ST_PASS: begin
        cmd_o.op = soc_pkg::OP_CLR;
        idx_d    = '0;
        state_d  = soc_pkg::ST_READ;
      end
      soc_pkg::ST_READ: begin
        cmd_o.op = soc_pkg::OP_READ;
        state_d  = soc_pkg::ST_DIFF;
      end
      soc_pkg::ST_DIFF: begin
        cmd_o.op = soc_pkg::OP_DIFF;
        ax_d     = '0;
        state_d  = soc_pkg::ST_MCS;
      end
      soc_pkg::ST_MCS: begin
        cmd_o.op = soc_pkg::OP_MUL_CS;
        state_d  = soc_pkg::ST_C;
      end
      soc_pkg::ST_C: begin
        cmd_o.op = soc_pkg::OP_C;
        state_d  = soc_pkg::ST_MSQ;
      end
      soc_pkg::ST_MSQ: begin
        cmd_o.op = soc_pkg::OP_MUL_SQ;
        state_d  = soc_pkg::ST_ASQ;
      end
      soc_pkg::ST_ASQ: begin
        cmd_o.op = soc_pkg::OP_ACC_SQ;
        if (ax_q == soc_pkg::AX_LAST) begin
          ax_d    = '0;
          state_d = soc_pkg::ST_SQS;
        end else begin
          ax_d    = ax_q + 3'd1;
          state_d = soc_pkg::ST_MCS;
        end
      end
      soc_pkg::ST_SQS: begin
        cmd_o.op = soc_pkg::OP_SQRT_START;
        state_d  = soc_pkg::ST_SQ;
      end
      soc_pkg::ST_SQ: begin
        cmd_o.op = soc_pkg::OP_SQRT_STEP;
        if (sts_i.iter_last) begin
          state_d = soc_pkg::ST_ERR;
        end
      end
      soc_pkg::ST_ERR: begin
        cmd_o.op = soc_pkg::OP_ERR;
        ax_d     = '0;
        state_d  = sts_i.norm_zero ? soc_pkg::ST_NEXT : soc_pkg::ST_DVS;
      end
      soc_pkg::ST_DVS: begin
        cmd_o.op = soc_pkg::OP_DIV_U_START;
        state_d  = soc_pkg::ST_DV;
      end
      soc_pkg::ST_DV: begin
        cmd_o.op = soc_pkg::OP_DIV_STEP;
        if (sts_i.iter_last) begin
          state_d = soc_pkg::ST_U;
        end
      end
      soc_pkg::ST_U: begin
        cmd_o.op = soc_pkg::OP_U;
        state_d  = soc_pkg::ST_MT;
      end
      soc_pkg::ST_MT: begin
        cmd_o.op = soc_pkg::OP_MUL_T;
        state_d  = soc_pkg::ST_T;
      end
      soc_pkg::ST_T: begin
        cmd_o.op = soc_pkg::OP_T;
        state_d  = soc_pkg::ST_MTS;
      end
      soc_pkg::ST_MTS: begin
        cmd_o.op = soc_pkg::OP_MUL_TS;
        state_d  = soc_pkg::ST_AO;
      end
      soc_pkg::ST_AO: begin
        cmd_o.op = soc_pkg::OP_ACC_O;
        state_d  = soc_pkg::ST_MTD;
      end
      soc_pkg::ST_MTD: begin
        cmd_o.op = soc_pkg::OP_MUL_TD;
        state_d  = soc_pkg::ST_AS;
      end
      soc_pkg::ST_AS: begin
        cmd_o.op = soc_pkg::OP_ACC_S;
        if (ax_q == soc_pkg::AX_LAST) begin
          state_d = soc_pkg::ST_NEXT;
        end else begin
          ax_d    = ax_q + 3'd1;
          state_d = soc_pkg::ST_DVS;
        end
      end
      soc_pkg::ST_NEXT: begin
        if ((CW'(idx_q) + CW'(1)) == count_q) begin
          ax_d    = '0;
          state_d = soc_pkg::ST_GDS;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = soc_pkg::ST_READ;
        end
      end
      soc_pkg::ST_GDS: begin
        cmd_o.op = soc_pkg::OP_DIV_G_START;
        state_d  = soc_pkg::ST_GD;
      end
      soc_pkg::ST_GD: begin
        cmd_o.op = soc_pkg::OP_DIV_STEP;
        if (sts_i.iter_last) begin
          state_d = soc_pkg::ST_M;
        end
      end
      soc_pkg::ST_M: begin
        cmd_o.op = soc_pkg::OP_M;
        state_d  = soc_pkg::ST_MPH;
      end
      soc_pkg::ST_MPH: begin
        cmd_o.op = soc_pkg::OP_MUL_PH;
        state_d  = soc_pkg::ST_PH;
      end
      soc_pkg::ST_PH: begin
        cmd_o.op = soc_pkg::OP_P_HI;
        state_d  = soc_pkg::ST_MPL;
      end
      soc_pkg::ST_MPL: begin
        cmd_o.op = soc_pkg::OP_MUL_PL;
        state_d  = soc_pkg::ST_UPD;
      end
      soc_pkg::ST_UPD: begin
        cmd_o.op = soc_pkg::OP_UPD;
        if (ax_q == soc_pkg::EST_LAST) begin
          state_d = soc_pkg::ST_PEND;
        end else begin
          ax_d    = ax_q + 3'd1;
          state_d = soc_pkg::ST_GDS;
        end
      end
      soc_pkg::ST_PEND: begin
        pass_d  = pass_q + 16'd1;
        state_d = ((17'(pass_q) + 17'd1) == 17'(iter_count_i)) ? soc_pkg::ST_DONE
                                                              : soc_pkg::ST_PASS;
      end
      soc_pkg::ST_DONE: begin
        if (!out_busy_i) begin
          load_out_o = 1'b1;
          count_d    = '0;
          state_d    = soc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = soc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/soc_dpath.sv =====
// ----------------------------------------------------------------------------
// soc_dpath
// sample store, shared multiplier, square root and divider, estimates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soc_dpath #(
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire soc_pkg::cmd_t                      cmd_i,
  output soc_pkg::sts_t                           sts_o,
  input  wire logic [$clog2(MAX_SAMPLES)-1:0]     addr_i,
  input  wire logic [$clog2(MAX_SAMPLES+1)-1:0]   count_i,
  input  wire logic [47:0]                        sample_i,
  input  wire logic [14:0]                        tn_i,
  input  wire logic [23:0]                        lr_i,
  output logic [191:0]                            result_o
);

  logic [47:0] mem [MAX_SAMPLES];
  logic [47:0] rd_q;

  logic signed [31:0] o_q [3];
  logic signed [31:0] s_q [3];
  logic signed [47:0] g_q [6];
  logic signed [31:0] d_q [3];
  logic signed [31:0] c_q [3];
  logic signed [31:0] dnext [3];
  logic [63:0]        sq_q;
  logic signed [31:0] err_q;
  logic signed [31:0] u_q;
  logic signed [32:0] t_q;
  logic [47:0]        mm_q;
  logic               mneg_q;
  logic [47:0]        p_q;
  logic [63:0]        prod_q;
  logic               pneg_q;
  logic [63:0]        sx_q, sres_q, sbit_q;
  logic [31:0]        rem_q, den_q;
  logic [63:0]        num_q;
  logic [6:0]         cnt_q;

  logic [1:0]         axl;
  logic [2:0]         sax;
  logic [2:0]         eax;
  logic signed [32:0] ma, mb;
  logic [31:0]        mag_a, mag_b;
  logic [63:0]        mprod;
  logic signed [65:0] ps16, ps30;
  logic [64:0]        ssum;
  logic               sge;
  logic [32:0]        r2, rdiff;
  logic               dge;
  logic [48:0]        ptot;
  logic signed [65:0] stepv;
  logic signed [65:0] errv;
  logic [47:0]        magg;

  assign axl  = cmd_i.ax[1:0];
  assign sax  = cmd_i.ax + 3'd3;
  assign eax  = cmd_i.ax - 3'd3;

  assign sts_o.iter_last = (cnt_q == 7'd1);
  assign sts_o.norm_zero = (sres_q == 64'd0);

  assign result_o = {s_q[2], s_q[1], s_q[0], o_q[2], o_q[1], o_q[0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == soc_pkg::OP_WRITE) begin
      mem[addr_i] <= sample_i;
    end
    if (cmd_i.op == soc_pkg::OP_READ) begin
      rd_q <= mem[addr_i];
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      soc_pkg::OP_MUL_CS: begin
        ma = 33'(d_q[axl]);
        mb = 33'(s_q[axl]);
      end
      soc_pkg::OP_MUL_SQ: begin
        ma = 33'(c_q[axl]);
        mb = 33'(c_q[axl]);
      end
      soc_pkg::OP_MUL_T: begin
        ma = 33'(err_q);
        mb = 33'(u_q);
      end
      soc_pkg::OP_MUL_TS: begin
        ma = t_q;
        mb = 33'(s_q[axl]);
      end
      soc_pkg::OP_MUL_TD: begin
        ma = t_q;
        mb = 33'(d_q[axl]);
      end
      soc_pkg::OP_MUL_PH: begin
        ma = $signed({9'd0, mm_q[47:24]});
        mb = $signed({9'd0, lr_i});
      end
      soc_pkg::OP_MUL_PL: begin
        ma = $signed({9'd0, mm_q[23:0]});
        mb = $signed({9'd0, lr_i});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mag_a = soc_pkg::mag_f(ma);
  assign mag_b = soc_pkg::mag_f(mb);
  assign mprod = mag_a * mag_b;

  assign ps16 = pneg_q ? -$signed({18'd0, prod_q[63:16]}) : $signed({18'd0, prod_q[63:16]});
  assign ps30 = pneg_q ? -$signed({32'd0, prod_q[63:30]}) : $signed({32'd0, prod_q[63:30]});

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dnext[a] = soc_pkg::sat32_f((66'($signed(rd_q[16*a +: 16])) <<< 4) - 66'(o_q[a]));
    end
  end

  assign ssum  = {1'b0, sres_q} + {1'b0, sbit_q};
  assign sge   = {1'b0, sx_q} >= ssum;
  assign r2    = {rem_q, num_q[63]};
  assign rdiff = r2 - {1'b0, den_q};
  assign dge   = r2 >= {1'b0, den_q};
  assign ptot  = {1'b0, p_q} + {9'd0, prod_q[63:24]};
  assign stepv = mneg_q ? -$signed({17'd0, ptot}) : $signed({17'd0, ptot});
  assign errv  = ($signed({34'd0, sres_q[31:0]}) - $signed({47'd0, tn_i, 4'd0})) <<< 1;
  assign magg  = g_q[cmd_i.ax][47] ? 48'(-g_q[cmd_i.ax]) : 48'(g_q[cmd_i.ax]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (cmd_i.op)
        soc_pkg::OP_SQRT_START:                          cnt_q <= soc_pkg::SQRT_STEPS;
        soc_pkg::OP_DIV_U_START, soc_pkg::OP_DIV_G_START: cnt_q <= soc_pkg::DIV_STEPS;
        soc_pkg::OP_SQRT_STEP, soc_pkg::OP_DIV_STEP:     cnt_q <= cnt_q - 7'd1;
        default:                                         cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      soc_pkg::OP_INIT: begin
        for (int a = 0; a < 3; a++) begin
          o_q[a] <= '0;
          s_q[a] <= soc_pkg::Q16_ONE;
        end
      end
      soc_pkg::OP_CLR: begin
        for (int a = 0; a < 6; a++) begin
          g_q[a] <= '0;
        end
      end
      soc_pkg::OP_DIFF: begin
        for (int a = 0; a < 3; a++) begin
          d_q[a] <= dnext[a];
        end
      end
      soc_pkg::OP_MUL_CS, soc_pkg::OP_MUL_SQ, soc_pkg::OP_MUL_T, soc_pkg::OP_MUL_TS,
      soc_pkg::OP_MUL_TD, soc_pkg::OP_MUL_PH, soc_pkg::OP_MUL_PL: begin
        prod_q <= mprod;
        pneg_q <= ma[32] ^ mb[32];
      end
      soc_pkg::OP_C: begin
        c_q[axl] <= soc_pkg::sat32_f(ps16);
      end
      soc_pkg::OP_ACC_SQ: begin
        sq_q <= ((axl == 2'd0) ? 64'd0 : sq_q) + prod_q;
      end
      soc_pkg::OP_SQRT_START: begin
        sx_q   <= sq_q;
        sres_q <= '0;
        sbit_q <= 64'd1 << 62;
      end
      soc_pkg::OP_SQRT_STEP: begin
        if (sge) begin
          sx_q   <= sx_q - ssum[63:0];
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      soc_pkg::OP_ERR: begin
        err_q <= soc_pkg::sat32_f(errv);
      end
      soc_pkg::OP_DIV_U_START: begin
        num_q <= {2'd0, soc_pkg::mag_f(33'(c_q[axl])), 30'd0};
        den_q <= sres_q[31:0];
        rem_q <= '0;
      end
      soc_pkg::OP_DIV_G_START: begin
        num_q  <= {16'd0, magg};
        den_q  <= 32'(count_i);
        rem_q  <= '0;
        mneg_q <= g_q[cmd_i.ax][47];
      end
      soc_pkg::OP_DIV_STEP: begin
        rem_q <= dge ? rdiff[31:0] : r2[31:0];
        num_q <= {num_q[62:0], dge};
      end
      soc_pkg::OP_U: begin
        u_q <= c_q[axl][31] ? -$signed(num_q[31:0]) : $signed(num_q[31:0]);
      end
      soc_pkg::OP_T: begin
        t_q <= ps30[32:0];
      end
      soc_pkg::OP_ACC_O: begin
        g_q[cmd_i.ax] <= soc_pkg::sat48_f(66'(g_q[cmd_i.ax]) - ps16);
      end
      soc_pkg::OP_ACC_S: begin
        g_q[sax] <= soc_pkg::sat48_f(66'(g_q[sax]) + ps16);
      end
      soc_pkg::OP_M: begin
        mm_q <= num_q[47:0];
      end
      soc_pkg::OP_P_HI: begin
        p_q <= prod_q[47:0];
      end
      soc_pkg::OP_UPD: begin
        if (cmd_i.ax < 3'd3) begin
          o_q[axl] <= soc_pkg::sat32_f(66'(o_q[axl]) - stepv);
        end else begin
          s_q[eax[1:0]] <= soc_pkg::sat32_f(66'(s_q[eax[1:0]]) - stepv);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/soc_checker.sv =====
// ----------------------------------------------------------------------------
// soc_checker
// port-level checks of the calibrator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          s_axis_tvalid_i,
  input wire logic          s_axis_tready_o,
  input wire logic          s_axis_tlast_i,
  input wire logic          m_axis_tvalid_o,
  input wire logic          m_axis_tready_i,
  input wire logic [191:0]  m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input still open after last sample");

  a_result_from_solve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a solve");

endmodule

bind sensor_offset_scale_calibrator soc_checker u_soc_checker (.*);

`default_nettype wire

// ===== verif/sensor_offset_scale_calibrator_checker.sv =====
// ----------------------------------------------------------------------------
// sensor_offset_scale_calibrator_checker
// watches the sample, result and register ports, fits the expected offsets
// and scales for each completed sample set and compares every result transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_offset_scale_calibrator_checker #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [47:0]  s_axis_tdata_i,   // sample_x, sample_y, sample_z
  input  logic         s_axis_tlast_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [191:0] m_axis_tdata_i,   // offset_x/y/z, scale_x/y/z
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_wdata_i,
  output int           err_count_o,
  output int           pending_o
);

  localparam longint S32_LO = -64'sd2147483648;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S48_LO = -64'sd140737488355328;
  localparam longint S48_HI = 64'sd140737488355327;

  int              smp [MAX_SAMPLES][3];
  int              smp_cnt;
  longint          ofs [3];
  longint          scl [3];
  longint          tgt_norm;
  longint          lrate;
  int              passes;
  logic [191:0]    fit_q [$];
  string           fld_name [6] = '{"offset_x", "offset_y", "offset_z",
                                    "scale_x", "scale_y", "scale_z"};

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit [63:0] mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint mul_trunc(longint a, longint b, int sh);
    bit [63:0] r;
    r = (mag(a) * mag(b)) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic descent_pass();
    longint    g [6];
    longint    d [3];
    longint    c [3];
    longint    err, u, t, m, step;
    bit [63:0] sq, nrm, uq, mm, p;
    int        n;
    n = smp_cnt < MAX_SAMPLES ? smp_cnt : MAX_SAMPLES;
    for (int a = 0; a < 6; a++) g[a] = 0;
    for (int i = 0; i < n; i++) begin
      sq = 0;
      for (int a = 0; a < 3; a++) begin
        d[a] = clip(longint'(smp[i][a]) * 16 - ofs[a], S32_LO, S32_HI);
        c[a] = clip(mul_trunc(d[a], scl[a], 16), S32_LO, S32_HI);
        sq += 64'(c[a] * c[a]);
      end
      nrm = int_sqrt(sq);
      if (nrm == 0) continue;
      err = clip(2 * (longint'(nrm) - tgt_norm * 16), S32_LO, S32_HI);
      for (int a = 0; a < 3; a++) begin
        uq = (mag(c[a]) << 30) / nrm;
        u = c[a] < 0 ? -longint'(uq) : longint'(uq);
        t = mul_trunc(err, u, 30);
        g[a] = clip(g[a] - mul_trunc(t, scl[a], 16), S48_LO, S48_HI);
        g[3+a] = clip(g[3+a] + mul_trunc(t, d[a], 16), S48_LO, S48_HI);
      end
    end
    if (smp_cnt == 0) return;
    for (int a = 0; a < 6; a++) begin
      m = g[a] / longint'(smp_cnt);
      mm = mag(m);
      p = (mm >> 24) * lrate + (((mm & 64'hFFFFFF) * lrate) >> 24);
      step = m < 0 ? -longint'(p) : longint'(p);
      if (a < 3) ofs[a] = clip(ofs[a] - step, S32_LO, S32_HI);
      else scl[a-3] = clip(scl[a-3] - step, S32_LO, S32_HI);
    end
  endtask

  task automatic fit_set();
    logic [191:0] r;
    for (int a = 0; a < 3; a++) begin
      ofs[a] = 0;
      scl[a] = soc_pkg::Q16_ONE;
    end
    for (int k = 0; k < passes; k++) descent_pass();
    for (int a = 0; a < 3; a++) begin
      r[32*a +: 32] = ofs[a][31:0];
      r[32*(a+3) +: 32] = scl[a][31:0];
    end
    fit_q.push_back(r);
    smp_cnt = 0;
  endtask

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    err_count_o++;
  endtask

  initial begin
    err_count_o = 0;
  end

  assign pending_o = fit_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [191:0] want;
    if (!rst_ni) begin
      smp_cnt = 0;
      tgt_norm = soc_pkg::TARGET_NORM_RST;
      lrate = soc_pkg::LEARN_RATE_RST;
      passes = soc_pkg::ITER_COUNT_RST;
      fit_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          soc_pkg::REG_TARGET_NORM: tgt_norm = cfg_wdata_i[14:0];
          soc_pkg::REG_LEARN_RATE:  lrate = cfg_wdata_i[23:0];
          soc_pkg::REG_ITER_COUNT:  passes = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (fit_q.size() == 0) begin
          report("result transfer with no fit outstanding");
        end else begin
          want = fit_q.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (m_axis_tdata_i[32*f +: 32] !== want[32*f +: 32]) begin
              report($sformatf("%s got %0d expected %0d", fld_name[f],
                     $signed(m_axis_tdata_i[32*f +: 32]), $signed(want[32*f +: 32])));
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (smp_cnt < MAX_SAMPLES) begin
          for (int a = 0; a < 3; a++) smp[smp_cnt][a] = $signed(s_axis_tdata_i[16*a +: 16]);
          smp_cnt++;
        end
        if (s_axis_tlast_i) fit_set();
      end
    end
  end

endmodule

// ===== verif/sensor_offset_scale_calibrator_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_offset_scale_calibrator_tb
// drives sample sets and register settings into the calibrator, stalls the
// result side, and takes the verdict from the checker beside the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_offset_scale_calibrator_tb;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_idx;
  logic [23:0]  cfg_wdata;
  int           err_count;
  int           pending;
  int           burst_left;
  int           n_items;
  int           stall_mode;

  sensor_offset_scale_calibrator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  sensor_offset_scale_calibrator_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .err_count_o     (err_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side stall pattern, mode changes at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic push_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
  endtask

  // waits until every fit has come out, then lets the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [14:0] tn, logic [23:0] lr, logic [15:0] it);
    drain();
    write_reg(soc_pkg::REG_TARGET_NORM, {9'd0, tn});
    write_reg(soc_pkg::REG_LEARN_RATE, lr);
    write_reg(soc_pkg::REG_ITER_COUNT, {8'd0, it});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] axis_val(int mode);
    int v;
    if (mode == 0) return 16'($urandom_range(0, 65535));
    v = $urandom_range(0, 6000) - 3000 + ($urandom_range(0, 1) ? 4096 : -4096);
    return v[15:0];
  endfunction

  task automatic random_set(int n, int mode);
    for (int i = 0; i < n; i++) begin
      push_sample(axis_val(mode), axis_val(mode), axis_val(mode), i == n - 1);
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = soc_pkg::REG_TARGET_NORM;
    cfg_wdata = '0;
    burst_left = 0;
    n_items = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // extremes, zero length sample and maximum step
    set_regs(15'd4096, 24'hFFFFFF, 16'd3);
    push_sample(16'h7FFF, 16'h8000, 16'h0000, 1'b0);
    push_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
    push_sample(16'h0000, 16'h0000, 16'h0000, 1'b1);
    push_sample(16'h1000, 16'h0000, 16'h0000, 1'b1);
    // no passes at all
    set_regs(15'd1, 24'd0, 16'd0);
    push_sample(16'h1234, 16'hFEDC, 16'h0800, 1'b0);
    push_sample(16'h0100, 16'h0200, 16'h0300, 1'b1);
    // target zero, then target at its top, zero step factor
    set_regs(15'd0, 24'd16777, 16'd2);
    push_sample(16'h0800, 16'hF800, 16'h0400, 1'b0);
    push_sample(16'h0000, 16'h0000, 16'h0000, 1'b1);
    set_regs(15'd32767, 24'd0, 16'd2);
    push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    set_regs(15'd32767, 24'hFFFFFF, 16'd4);
    push_sample(16'h8000, 16'h8000, 16'h8000, 1'b0);
    push_sample(16'h4000, 16'hC000, 16'h2000, 1'b1);
    // many passes on a tiny set
    set_regs(15'd4096, 24'd400000, 16'd200);
    push_sample(16'h1000, 16'h0100, 16'hFF00, 1'b0);
    push_sample(16'hF000, 16'h0200, 16'h0080, 1'b1);
    // store overflow, the dropped flagged sample still starts the fit
    set_regs(15'd4096, 24'd100000, 16'd1);
    random_set(258, 1);
    drain();

    while (n_items < 1600) begin
      if ($urandom_range(0, 9) == 0) begin
        set_regs(15'($urandom_range(0, 32767)), 24'($urandom_range(0, 24'hFFFFFF)),
                 16'($urandom_range(0, 2)));
      end
      if ($urandom_range(0, 19) == 0) random_set($urandom_range(20, 40), $urandom_range(0, 1));
      else random_set($urandom_range(1, 10), $urandom_range(0, 3) == 0 ? 0 : 1);
    end
    drain();
    repeat (50) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
